@@ rtl/downsample_moving_average_unit_defines.svh @@
// Assertion macros for the downsample moving average unit.
// Used by the top level; expects signals clk and rst in scope.
`ifndef DOWNSAMPLE_MOVING_AVERAGE_UNIT_DEFINES_SVH
`define DOWNSAMPLE_MOVING_AVERAGE_UNIT_DEFINES_SVH

// Same-cycle implication checked at every rising edge outside reset.
`define DSMA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked at every rising edge outside reset.
`define DSMA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/dsma_pkg.sv @@
// Shared types and constants of the downsample moving average unit.
// No dependencies; imported by the top level, dsma_front, dsma_back and the testbench.
`default_nettype none
package dsma_pkg;

  localparam int CFG_W  = 17;
  localparam int MEAN_W = 48;
  localparam int POS_W  = 16;
  localparam int WIN_W  = 17;
  localparam int SMP_W  = 32;
  localparam int IDX_W  = 2;

  localparam logic [IDX_W-1:0] REG_SMOOTHING  = 2'd0;
  localparam logic [IDX_W-1:0] REG_MAX_POINTS = 2'd1;
  localparam logic [IDX_W-1:0] REG_CIRCULAR   = 2'd2;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_FETCH = 1'b1;

  localparam logic [CFG_W-1:0] SMOOTH_ONE = 17'h10000;
  localparam int               ROUND_HALF = 32768;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  typedef enum logic [1:0] {
    PH_LOADING,
    PH_OUTPUT,
    PH_DONE
  } phase_t;

  typedef enum logic [3:0] {
    ST_RUN,
    ST_CL_START,
    ST_CL_STRIDE,
    ST_CL_M_GO,
    ST_CL_M,
    ST_CL_MUL,
    ST_CL_FIN,
    ST_F_ADDR,
    ST_F_RD_A,
    ST_F_RD_B,
    ST_F_RD_C,
    ST_F_SUM,
    ST_F_DIV
  } state_t;

  typedef struct packed {
    logic             is_fetch;
    logic             final_sample;
    logic [SMP_W-1:0] sample;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fr_stat_t;

  typedef struct packed {
    logic [CFG_W-1:0] smoothing_frac;
    logic [CFG_W-1:0] max_points;
    logic             circular_mode;
  } cfg_t;

endpackage
`default_nettype wire

@@ rtl/downsample_moving_average_unit.sv @@
// Top level of the downsample moving average unit: configuration registers,
// front queue and back end. Depends on dsma_pkg, dsma_front, dsma_back and
// the assertion macros in downsample_moving_average_unit_defines.svh.
//
// A command transaction is taken when start is high and busy is low. A load
// (action 0) appends one sample to the prefix store; the sample flagged
// final_sample closes the set. A fetch (action 1) returns the next output
// point one time on strobe, with position, mean_value, window_used and
// last_point; the receiver cannot stall, so each result is shown for one cycle.
// Commands go through a four-entry queue, and busy is high while it is full.
// A load is handled in the run state of the back end. Closing a set makes
// two passes of the divider, which yields one quotient bit per cycle. A
// fetch makes three reads of the single prefix store port, then one
// divider pass. Fetches while loading or after the last point return nothing.
// Configuration is written through wr_en, wr_index and wr_data. Reset clears
// counts, queue and registers.
`default_nettype none
`include "downsample_moving_average_unit_defines.svh"
module downsample_moving_average_unit #(
  parameter int MAX_SAMPLES = 65536,
  parameter int SAMPLE_BITS = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  output logic                         busy,
  input  wire                          action,
  input  wire [dsma_pkg::SMP_W-1:0]    sample,
  input  wire                          final_sample,
  input  wire                          wr_en,
  input  wire [dsma_pkg::IDX_W-1:0]    wr_index,
  input  wire [dsma_pkg::CFG_W-1:0]    wr_data,
  output logic                         strobe,
  output logic [dsma_pkg::POS_W-1:0]   position,
  output logic [dsma_pkg::MEAN_W-1:0]  mean_value,
  output logic [dsma_pkg::WIN_W-1:0]   window_used,
  output logic                         last_point
);
  import dsma_pkg::*;

  cfg_t     cfg;
  cmd_t     head;
  fr_stat_t q_stat;
  logic     pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_SMOOTHING:  cfg.smoothing_frac <= wr_data;
        REG_MAX_POINTS: cfg.max_points     <= wr_data;
        REG_CIRCULAR:   cfg.circular_mode  <= wr_data[0];
        default:        cfg <= cfg;
      endcase
    end
  end

  dsma_front u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .action      (action),
    .sample      (sample),
    .final_sample(final_sample),
    .pop         (pop),
    .head        (head),
    .stat        (q_stat)
  );

  dsma_back #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .SAMPLE_BITS(SAMPLE_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head       (head),
    .stat       (q_stat),
    .pop        (pop),
    .position   (position),
    .mean_value (mean_value),
    .window_used(window_used),
    .last_point (last_point),
    .strobe     (strobe)
  );

  `DSMA_ASSERT_NOW(a_queue_state, 1'b1, !(q_stat.full && q_stat.empty), "queue full and empty")
  `DSMA_ASSERT_NEXT(a_strobe_gap, strobe, !strobe, "results on adjacent cycles")
  `DSMA_ASSERT_NOW(a_window_nonzero, strobe, window_used != '0, "zero window on result")

endmodule
`default_nettype wire

@@ rtl/dsma_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module dsma_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 65536
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] waddr,
  input  wire [WIDTH-1:0]         wdata,
  input  wire [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/dsma_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
// Depends on nothing but its parameters.
`default_nettype none
module dsma_div #(
  parameter int DW = 64,
  parameter int VW = 17
) (
  input  wire           clk,
  input  wire           rst,
  input  wire           go,
  input  wire [DW-1:0]  dividend,
  input  wire [VW-1:0]  divisor,
  output logic          done,
  output logic [DW-1:0] quotient,
  output logic [VW-1:0] remainder
);

  localparam int NW = $clog2(DW + 1);

  logic [VW-1:0] dvs;
  logic [NW-1:0] cnt;
  logic          running;
  logic [VW:0]   trial;
  logic          fits;

  assign trial = {remainder, quotient[DW-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else if (go) begin
      running <= 1'b1;
      done    <= 1'b0;
      cnt     <= NW'(DW);
    end else if (running) begin
      cnt     <= cnt - 1'b1;
      running <= cnt != NW'(1);
      done    <= cnt == NW'(1);
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      quotient  <= dividend;
      remainder <= '0;
      dvs       <= divisor;
    end else if (running) begin
      if (fits) begin
        remainder <= VW'(trial - {1'b0, dvs});
        quotient  <= {quotient[DW-2:0], 1'b1};
      end else begin
        remainder <= trial[VW-1:0];
        quotient  <= {quotient[DW-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/dsma_front.sv @@
// Front end: accepts and classifies command transactions into a short queue.
// Depends on dsma_pkg.
`default_nettype none
module dsma_front (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         start,
  output logic                        busy,
  input  wire                         action,
  input  wire [dsma_pkg::SMP_W-1:0]   sample,
  input  wire                         final_sample,
  input  wire                         pop,
  output dsma_pkg::cmd_t              head,
  output dsma_pkg::fr_stat_t          stat
);
  import dsma_pkg::*;

  cmd_t         q [QDEPTH];
  logic [QAW-1:0] wp;
  logic [QAW-1:0] rp;
  logic [QAW:0]   cnt;
  logic           push;
  logic           take;

  assign stat.empty = cnt == '0;
  assign stat.full  = cnt == (QAW+1)'(QDEPTH);
  assign busy       = stat.full;
  assign push       = start && !stat.full;
  assign take       = pop && !stat.empty;
  assign head       = q[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (take) begin
        rp <= rp + 1'b1;
      end
      cnt <= cnt + (QAW+1)'(push) - (QAW+1)'(take);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= '{is_fetch: action == ACT_FETCH, final_sample: final_sample,
                 sample: sample};
    end
  end

endmodule
`default_nettype wire

@@ rtl/dsma_back.sv @@
// Back end: prefix store, set closing arithmetic and windowed mean per fetch.
// Depends on dsma_pkg, dsma_ram and dsma_div.
`default_nettype none
module dsma_back #(
  parameter int MAX_SAMPLES = 65536,
  parameter int SAMPLE_BITS = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire                          clk,
  input  wire                          rst,
  input  dsma_pkg::cfg_t               cfg,
  input  dsma_pkg::cmd_t               head,
  input  dsma_pkg::fr_stat_t           stat,
  output logic                         pop,
  output logic [dsma_pkg::POS_W-1:0]   position,
  output logic [dsma_pkg::MEAN_W-1:0]  mean_value,
  output logic [dsma_pkg::WIN_W-1:0]   window_used,
  output logic                         last_point,
  output logic                         strobe
);
  import dsma_pkg::*;

  localparam int AW  = $clog2(MAX_SAMPLES);
  localparam int CW  = $clog2(MAX_SAMPLES + 1);
  localparam int CW1 = CW + 1;
  localparam int VW  = (CW > CFG_W) ? CW : CFG_W;
  localparam int XW  = VW + 1;
  localparam int DW  = MEAN_W + FRAC_BITS;
  localparam int PW  = CW + CFG_W;

  state_t state, state_next;
  phase_t phase;

  logic [MEAN_W-1:0] run_sum;
  logic [CW-1:0]     n_cnt, stride, window, next_ctr, m_q;
  logic [CW1-1:0]    emitted;
  logic [VW-1:0]     eff;
  logic [CFG_W-1:0]  s_cl;
  logic [PW-1:0]     wprod;
  logic [2*CW-1:0]   mprod;
  logic [CW-1:0]     fc, ka, kb, kc, len_r, wuse;
  logic              flast;
  logic [MEAN_W-1:0] pa, pb;

  // Load path.
  logic              is_new, room, closes, is_load, is_fetch;
  logic [CW-1:0]     base_cnt, cnt_new;
  logic [MEAN_W-1:0] base_sum, sum_new, smp;

  // Fetch setup.
  logic          f_last;
  logic [CW-1:0] f_c;

  // Window address computation.
  logic [CW-1:0]  half, cst, lstart, lend;
  logic [CW1-1:0] t_c, cend, le;
  logic           cwrap;
  logic [CW-1:0]  ka_n, kb_n, kc_n, len_n, wuse_n;

  // Set closing. The point budget is taken from the live register at each fetch.
  logic [PW-1:0]  wsum;
  logic [CW1-1:0] w0, w1, w2, w3;
  logic [CW1-1:0] total_n;
  logic           m_exact;
  logic [VW-1:0]  eff_now;

  // Memory and divider.
  logic              mem_we;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [MEAN_W-1:0] mem_rdata, pc;
  logic              div_go, div_done;
  logic [DW-1:0]     div_dvd, div_q;
  logic [VW-1:0]     div_dvs, div_r;

  // Result.
  logic              rnd, sat;
  logic [MEAN_W:0]   qsum;

  dsma_ram #(.WIDTH(MEAN_W), .DEPTH(MAX_SAMPLES)) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(sum_new),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  dsma_div #(.DW(DW), .VW(VW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q),
    .remainder(div_r)
  );

  assign is_load  = !stat.empty && !head.is_fetch;
  assign is_fetch = !stat.empty && head.is_fetch;
  assign is_new   = phase != PH_LOADING;
  assign base_cnt = is_new ? '0 : n_cnt;
  assign base_sum = is_new ? '0 : run_sum;
  assign room     = base_cnt < CW'(MAX_SAMPLES);
  assign smp      = MEAN_W'(head.sample[SAMPLE_BITS-1:0]);
  assign sum_new  = base_sum + smp;
  assign cnt_new  = room ? base_cnt + 1'b1 : base_cnt;
  assign closes   = head.final_sample && (cnt_new != '0);

  assign mem_we    = (state == ST_RUN) && is_load && room;
  assign mem_waddr = base_cnt[AW-1:0];

  assign eff_now = (cfg.max_points == '0) ? VW'(n_cnt) : VW'(cfg.max_points);

  assign f_last = (emitted + 1'b1) >= total_n;
  assign f_c    = f_last ? n_cnt - 1'b1 : next_ctr;

  always_comb begin
    half   = window >> 1;
    t_c    = CW1'(fc) + CW1'(n_cnt) - CW1'(half);
    cst    = (t_c >= CW1'(n_cnt)) ? CW'(t_c - CW1'(n_cnt)) : CW'(t_c);
    cend   = CW1'(cst) + CW1'(window);
    cwrap  = cend > CW1'(n_cnt);
    lstart = (fc > half) ? fc - half : '0;
    le     = CW1'(fc) + CW1'(half) + 1'b1;
    lend   = (le < CW1'(n_cnt)) ? CW'(le) : n_cnt;
    if (window <= CW'(1)) begin
      ka_n   = fc + 1'b1;
      kb_n   = fc;
      kc_n   = '0;
      len_n  = CW'(1);
      wuse_n = CW'(1);
    end else if (cfg.circular_mode) begin
      ka_n   = cwrap ? n_cnt : CW'(cend);
      kb_n   = cst;
      kc_n   = cwrap ? CW'(cend - CW1'(n_cnt)) : '0;
      len_n  = window;
      wuse_n = window;
    end else begin
      ka_n   = lend;
      kb_n   = lstart;
      kc_n   = '0;
      len_n  = lend - lstart;
      wuse_n = window;
    end
  end

  always_comb begin
    wsum = wprod + PW'(ROUND_HALF);
    w0   = CW1'(wsum >> 16);
    w1   = (w0 == '0) ? CW1'(1) : w0;
    w2   = (w1 > CW1'(n_cnt)) ? CW1'(n_cnt) : w1;
    if (w2 > CW1'(1) && !w2[0]) begin
      w3 = (w2 < CW1'(n_cnt)) ? w2 + 1'b1 : w2 - 1'b1;
    end else begin
      w3 = w2;
    end
    if (m_exact || (XW'(m_q) >= XW'(eff_now))) begin
      total_n = CW1'(m_q);
    end else begin
      total_n = CW1'(m_q) + 1'b1;
    end
  end

  assign pc = (kc == '0) ? '0 : mem_rdata;

  always_comb begin
    div_go  = 1'b0;
    div_dvd = '0;
    div_dvs = VW'(len_r);
    case (state)
      ST_CL_START: begin
        div_go  = 1'b1;
        div_dvd = DW'(n_cnt) + DW'(eff) - 1'b1;
        div_dvs = eff;
      end
      ST_CL_M_GO: begin
        div_go  = 1'b1;
        div_dvd = DW'(n_cnt) + DW'(stride) - 1'b1;
        div_dvs = VW'(stride);
      end
      ST_F_SUM: begin
        div_go  = 1'b1;
        div_dvd = {pa - pb + pc, {FRAC_BITS{1'b0}}};
      end
      default: begin
        div_go = 1'b0;
      end
    endcase
  end

  always_comb begin
    rnd  = {div_r, 1'b0} >= {1'b0, VW'(len_r)};
    qsum = {1'b0, div_q[MEAN_W-1:0]} + (MEAN_W+1)'(rnd);
    sat  = (|div_q[DW-1:MEAN_W]) || qsum[MEAN_W];
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    mem_raddr  = '0;
    unique case (state)
      ST_RUN: begin
        pop = !stat.empty;
        if (is_load && closes) begin
          state_next = ST_CL_START;
        end else if (is_fetch && phase == PH_OUTPUT) begin
          state_next = ST_F_ADDR;
        end
      end
      ST_CL_START:  state_next = ST_CL_STRIDE;
      ST_CL_STRIDE: state_next = div_done ? ST_CL_M_GO : ST_CL_STRIDE;
      ST_CL_M_GO:   state_next = ST_CL_M;
      ST_CL_M:      state_next = div_done ? ST_CL_MUL : ST_CL_M;
      ST_CL_MUL:    state_next = ST_CL_FIN;
      ST_CL_FIN:    state_next = ST_RUN;
      ST_F_ADDR:    state_next = ST_F_RD_A;
      ST_F_RD_A: begin
        mem_raddr  = AW'(ka - 1'b1);
        state_next = ST_F_RD_B;
      end
      ST_F_RD_B: begin
        mem_raddr  = AW'(kb - 1'b1);
        state_next = ST_F_RD_C;
      end
      ST_F_RD_C: begin
        mem_raddr  = AW'(kc - 1'b1);
        state_next = ST_F_SUM;
      end
      ST_F_SUM:     state_next = ST_F_DIV;
      ST_F_DIV:     state_next = div_done ? ST_RUN : ST_F_DIV;
      default:      state_next = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_LOADING;
      run_sum  <= '0;
      n_cnt    <= '0;
      stride   <= CW'(1);
      window   <= CW'(1);
      next_ctr <= '0;
      emitted  <= '0;
      strobe   <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        ST_RUN: begin
          if (is_load) begin
            phase   <= PH_LOADING;
            run_sum <= room ? sum_new : base_sum;
            n_cnt   <= cnt_new;
          end else if (is_fetch && phase == PH_OUTPUT) begin
            fc    <= f_c;
            flast <= f_last;
          end
          if (is_load && closes) begin
            eff  <= (cfg.max_points == '0) ? VW'(cnt_new) : VW'(cfg.max_points);
            s_cl <= (cfg.smoothing_frac > SMOOTH_ONE) ? SMOOTH_ONE : cfg.smoothing_frac;
          end
        end
        ST_CL_START: begin
          wprod <= PW'(n_cnt) * PW'(s_cl);
        end
        ST_CL_STRIDE: begin
          if (div_done) begin
            stride <= (div_q == '0) ? CW'(1) : CW'(div_q);
          end
        end
        ST_CL_M: begin
          if (div_done) begin
            m_q <= CW'(div_q);
          end
        end
        ST_CL_MUL: begin
          mprod <= (2*CW)'(m_q - 1'b1) * (2*CW)'(stride);
        end
        ST_CL_FIN: begin
          m_exact  <= mprod == (2*CW)'(n_cnt - 1'b1);
          window   <= (s_cl == '0) ? CW'(1) : CW'(w3);
          next_ctr <= '0;
          emitted  <= '0;
          phase    <= PH_OUTPUT;
        end
        ST_F_ADDR: begin
          ka    <= ka_n;
          kb    <= kb_n;
          kc    <= kc_n;
          len_r <= len_n;
          wuse  <= wuse_n;
        end
        ST_F_RD_B: begin
          pa <= (ka == '0) ? '0 : mem_rdata;
        end
        ST_F_RD_C: begin
          pb <= (kb == '0) ? '0 : mem_rdata;
        end
        ST_F_DIV: begin
          if (div_done) begin
            strobe      <= 1'b1;
            position    <= POS_W'(fc);
            mean_value  <= sat ? {MEAN_W{1'b1}} : qsum[MEAN_W-1:0];
            window_used <= WIN_W'(wuse);
            last_point  <= flast;
            emitted     <= emitted + 1'b1;
            next_ctr    <= next_ctr + stride;
            if (flast) begin
              phase <= PH_DONE;
            end
          end
        end
        default: begin
          strobe <= 1'b0;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ tb/sv/dsma_checker.sv @@
// Checker for the downsample moving average unit: watches the command,
// configuration and result ports, predicts each result and compares it.
// Depends on dsma_pkg; instantiated by tb_top beside the block.
`timescale 1ns / 1ps
module dsma_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        busy,
  input  logic                        action,
  input  logic [dsma_pkg::SMP_W-1:0]  sample,
  input  logic                        final_sample,
  input  logic                        wr_en,
  input  logic [dsma_pkg::IDX_W-1:0]  wr_index,
  input  logic [dsma_pkg::CFG_W-1:0]  wr_data,
  input  logic                        strobe,
  input  logic [dsma_pkg::POS_W-1:0]  position,
  input  logic [dsma_pkg::MEAN_W-1:0] mean_value,
  input  logic [dsma_pkg::WIN_W-1:0]  window_used,
  input  logic                        last_point,
  output int                          fail_count,
  output int                          pending
);
  import dsma_pkg::*;

  localparam longint unsigned MASK48 = 64'hFFFF_FFFF_FFFF;
  localparam int MAX_SAMPLES_TB = 65536;

  typedef struct {
    logic [POS_W-1:0]  pos;
    logic [MEAN_W-1:0] mean;
    logic [WIN_W-1:0]  win;
    logic              last;
  } point_t;

  point_t point_q[$];

  logic [MEAN_W-1:0] sum_mem [MAX_SAMPLES_TB];

  longint unsigned run_sum;
  int unsigned     n_loaded, stride_len, win_len, center, n_emitted;
  phase_t          set_phase;
  logic [CFG_W-1:0] smooth_reg, maxpts_reg;
  logic             circ_reg;

  function automatic longint unsigned prefix_upto(int unsigned k);
    if (k == 0 || k > MAX_SAMPLES_TB) return 0;
    return sum_mem[k-1];
  endfunction

  function automatic int unsigned budget();
    return (maxpts_reg == 0) ? n_loaded : maxpts_reg;
  endfunction

  function automatic longint unsigned rounded_mean(longint unsigned s, int unsigned len);
    longint unsigned q, r, res;
    q = s / len;
    r = s % len;
    if (q >= (64'd1 << 32)) return MASK48;
    res = (q << 16) + (((r << 17) + len) / (2 * longint'(len)));
    return (res > MASK48) ? MASK48 : res;
  endfunction

  task automatic close_set();
    int unsigned     eff, sm;
    longint unsigned w;
    eff = budget();
    sm = (smooth_reg > SMOOTH_ONE) ? SMOOTH_ONE : smooth_reg;
    stride_len = 32'((longint'(n_loaded) + eff - 1) / eff);
    if (stride_len < 1) stride_len = 1;
    w = 1;
    if (sm != 0) begin
      w = (longint'(n_loaded) * sm + 32768) >> 16;
      if (w < 1) w = 1;
      if (w > n_loaded) w = n_loaded;
      if (w > 1 && w[0] == 1'b0) w = (w < n_loaded) ? w + 1 : w - 1;
      if (w < 1) w = 1;
    end
    win_len = 32'(w);
    center = 0;
    n_emitted = 0;
    set_phase = PH_OUTPUT;
  endtask

  task automatic predict(logic act, logic [SMP_W-1:0] smp, logic fin);
    int unsigned     n, m, total, c, w, half, lo, hi;
    longint unsigned s;
    logic            is_last;
    point_t          p;
    if (act == ACT_LOAD) begin
      if (set_phase != PH_LOADING) begin
        run_sum = 0;
        n_loaded = 0;
        set_phase = PH_LOADING;
      end
      if (n_loaded < MAX_SAMPLES_TB) begin
        run_sum = (run_sum + smp) & MASK48;
        sum_mem[n_loaded] = run_sum[MEAN_W-1:0];
        n_loaded++;
      end
      if (fin && n_loaded > 0) close_set();
      return;
    end
    if (set_phase != PH_OUTPUT) return;
    n = n_loaded;
    m = 32'((longint'(n) + stride_len - 1) / stride_len);
    total = ((m - 1) * stride_len == n - 1 || m >= budget()) ? m : m + 1;
    is_last = (n_emitted + 1 >= total);
    c = is_last ? n - 1 : center;
    w = win_len;
    if (w <= 1) begin
      s = rounded_mean((prefix_upto(c + 1) - prefix_upto(c)) & MASK48, 1);
      w = 1;
    end else begin
      half = w / 2;
      if (circ_reg) begin
        lo = 32'((longint'(c) + n - half) % n);
        hi = lo + w;
        if (hi <= n) s = prefix_upto(hi) - prefix_upto(lo);
        else s = prefix_upto(n) - prefix_upto(lo) + prefix_upto(hi - n);
        s = rounded_mean(s & MASK48, w);
      end else begin
        lo = (c > half) ? c - half : 0;
        hi = (c + half + 1 < n) ? c + half + 1 : n;
        s = rounded_mean((prefix_upto(hi) - prefix_upto(lo)) & MASK48, hi - lo);
      end
    end
    p.pos = c[POS_W-1:0];
    p.mean = s[MEAN_W-1:0];
    p.win = w[WIN_W-1:0];
    p.last = is_last;
    point_q.insert(point_q.size(), p);
    n_emitted++;
    center += stride_len;
    if (is_last) set_phase = PH_DONE;
  endtask

  task automatic report(string what);
    $display("[%0t] result mismatch: %s", $time, what);
    fail_count++;
  endtask

  task automatic compare_point();
    point_t e;
    if (point_q.size() == 0) begin
      report($sformatf("unexpected result at position %0d", position));
      return;
    end
    e = point_q.pop_front();
    if (position !== e.pos)
      report($sformatf("position %0d, expected %0d", position, e.pos));
    if (mean_value !== e.mean)
      report($sformatf("mean_value %h, expected %h at position %0d",
                       mean_value, e.mean, e.pos));
    if (window_used !== e.win)
      report($sformatf("window_used %0d, expected %0d at position %0d",
                       window_used, e.win, e.pos));
    if (last_point !== e.last)
      report($sformatf("last_point %0b, expected %0b at position %0d",
                       last_point, e.last, e.pos));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      point_q.delete();
      fail_count = 0;
      run_sum = 0;
      n_loaded = 0;
      stride_len = 1;
      win_len = 1;
      center = 0;
      n_emitted = 0;
      set_phase = PH_LOADING;
      smooth_reg = '0;
      maxpts_reg = '0;
      circ_reg = 1'b0;
    end else begin
      if (strobe === 1'b1) compare_point();
      if (wr_en) begin
        case (wr_index)
          REG_SMOOTHING: begin
            smooth_reg = wr_data;
          end
          REG_MAX_POINTS: begin
            maxpts_reg = wr_data;
          end
          REG_CIRCULAR: begin
            circ_reg = wr_data[0];
          end
          default: begin
          end
        endcase
      end
      if (start && !busy) predict(action, sample, final_sample);
    end
    pending = point_q.size();
  end

endmodule

@@ tb/sv/tb_top.sv @@
// Top of the downsample moving average testbench: clock, reset, command and
// configuration stimulus, and the verdict. Depends on dsma_pkg, the block
// and dsma_checker, which predicts and compares every result.
`timescale 1ns / 1ps
module tb_top;
  import dsma_pkg::*;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic              action = ACT_LOAD;
  logic [SMP_W-1:0]  sample = '0;
  logic              final_sample = 1'b0;
  logic              wr_en = 1'b0;
  logic [IDX_W-1:0]  wr_index = REG_SMOOTHING;
  logic [CFG_W-1:0]  wr_data = '0;
  logic              strobe;
  logic [POS_W-1:0]  position;
  logic [MEAN_W-1:0] mean_value;
  logic [WIN_W-1:0]  window_used;
  logic              last_point;
  int                fail_count;
  int                pending;
  int                idle_pct = 0;
  int                sent = 0;
  int                idle_pct_list[3] = '{10, 53, 0};

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  downsample_moving_average_unit u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .sample(sample), .final_sample(final_sample), .wr_en(wr_en),
    .wr_index(wr_index), .wr_data(wr_data), .strobe(strobe),
    .position(position), .mean_value(mean_value),
    .window_used(window_used), .last_point(last_point)
  );

  dsma_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .sample(sample), .final_sample(final_sample), .wr_en(wr_en),
    .wr_index(wr_index), .wr_data(wr_data), .strobe(strobe),
    .position(position), .mean_value(mean_value),
    .window_used(window_used), .last_point(last_point),
    .fail_count(fail_count), .pending(pending)
  );

  task automatic send_cmd(logic act, logic [SMP_W-1:0] smp, logic fin);
    int gap;
    gap = ($urandom_range(0, 99) < idle_pct) ? int'($urandom_range(1, 4)) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    action <= act;
    sample <= smp;
    final_sample <= fin;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic configure(logic [CFG_W-1:0] sm, logic [CFG_W-1:0] mp, logic circ);
    drain();
    write_reg(REG_SMOOTHING, sm);
    write_reg(REG_MAX_POINTS, mp);
    write_reg(REG_CIRCULAR, {{(CFG_W-1){1'b0}}, circ});
  endtask

  function automatic logic [SMP_W-1:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return $urandom_range(0, 1000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] rand_cfg();
    case ($urandom_range(0, 6))
      0: return '0;
      1: return 17'h10000;
      2: return '1;
      3: return CFG_W'($urandom_range(1, 8));
      default: return CFG_W'($urandom_range(0, 131071));
    endcase
  endfunction

  // One data set: loads with the final flag on the last, then fetches.
  // Some sets are cut short by the next load; some get extra fetches.
  task automatic run_set(int n, int fetches);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0)
        send_cmd(ACT_FETCH, $urandom, 1'($urandom_range(0, 1)));
      send_cmd(ACT_LOAD, rand_sample(), i == n - 1);
    end
    for (int i = 0; i < fetches; i++)
      send_cmd(ACT_FETCH, $urandom, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int n;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_cmd(ACT_FETCH, '0, 1'b0);
    send_cmd(ACT_LOAD, '0, 1'b0);
    send_cmd(ACT_LOAD, '1, 1'b0);
    send_cmd(ACT_LOAD, 32'd5, 1'b1);
    repeat (4) send_cmd(ACT_FETCH, '1, 1'b1);
    configure(17'h10000, 17'd2, 1'b1);
    send_cmd(ACT_LOAD, '1, 1'b0);
    send_cmd(ACT_LOAD, '1, 1'b0);
    send_cmd(ACT_LOAD, 32'd7, 1'b0);
    send_cmd(ACT_LOAD, '0, 1'b1);
    repeat (3) send_cmd(ACT_FETCH, '0, 1'b0);
    configure('1, '1, 1'b0);
    send_cmd(ACT_LOAD, 32'hA5A5_5A5A, 1'b0);
    send_cmd(ACT_LOAD, 32'h5A5A_A5A5, 1'b1);
    repeat (3) send_cmd(ACT_FETCH, '0, 1'b0);
    sent = 0;

    foreach (idle_pct_list[k]) begin
      idle_pct = idle_pct_list[k];
      while (sent < 135 * (k + 1)) begin
        if ($urandom_range(0, 2) == 0)
          configure(rand_cfg(), rand_cfg(), 1'($urandom_range(0, 1)));
        n = ($urandom_range(0, 9) == 0) ? int'($urandom_range(25, 80))
                                         : int'($urandom_range(1, 24));
        run_set(n, ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, n))
                                                : n + int'($urandom_range(0, 2)));
        if ($urandom_range(0, 3) == 0) drain();
      end
    end
    drain();

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
